// ===== rtl/pfgc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfgc_pkg
// shared types, codes and defaults of the gather crossbar
// ----------------------------------------------------------------------------
`default_nettype none
package pfgc_pkg;

  localparam int NUM_IN_CHANNELS_D = 4;
  localparam int IN_ELEMS_D        = 32;
  localparam int OUT_ELEMS_D       = 32;
  localparam int FIFO_DEPTH_D      = 16;
  localparam int MAX_INSTR_D       = 64;
  localparam int MAX_STEPS_D       = 8;

  localparam int ENTRY_W = 15;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ELEM = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [1:0] SEL_IN  = 2'd0;
  localparam logic [1:0] SEL_TBL = 2'd1;
  localparam logic [1:0] SEL_CUR = 2'd2;

  localparam logic [0:0] REG_PROG_LEN = 1'b0;
  localparam logic [0:0] REG_OUT_CHS  = 1'b1;

  typedef struct packed {
    logic       load_wr;
    logic       elem_wr;
    logic       push_begin;
    logic       push_rd;
    logic       push_wr;
    logic       chk_begin;
    logic       chk_next;
    logic       run_begin;
    logic       step_latch;
    logic       el_out;
    logic       step_end;
    logic       pad;
    logic       finish;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic elem_ok;
    logic word_done;
    logic sel_full;
    logic src_empty;
    logic tbl_final;
    logic tbl_no_range;
    logic k_end;
    logic step_final;
    logic push_last;
    logic eid_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/programmable_fifo_gather_crossbar_unit.sv =====
// ----------------------------------------------------------------------------
// programmable_fifo_gather_crossbar_unit
// instruction driven gather from input fifos into round robin output vectors
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  command   start / busy           mode, load step, element fields
//  result    strobe (one cycle)     out_value, out_position, dest_channel,
//                                   last_of_vector
//  config    apb psel/penable       program_length @0, output_channel_count @4
//
//  load step: writes one table entry; memory element: writes one buffer
//  entry, and a completed word is copied from the assembly buffer into its fifo
//  unless that fifo is full; tick: a readiness check walks the steps, then each
//  step reads its entry and the elements of its range one by one, then padding
//  elements end the vector; the table and store rams have registered reads
//  reset clears state, counters, pointers, buffer valid flags, config and strobe only; no clearing pass
//  results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
`default_nettype none
module programmable_fifo_gather_crossbar_unit #(
  parameter int NUM_IN_CHANNELS = pfgc_pkg::NUM_IN_CHANNELS_D,
  parameter int IN_ELEMS        = pfgc_pkg::IN_ELEMS_D,
  parameter int OUT_ELEMS       = pfgc_pkg::OUT_ELEMS_D,
  parameter int FIFO_DEPTH      = pfgc_pkg::FIFO_DEPTH_D,
  parameter int MAX_INSTR       = pfgc_pkg::MAX_INSTR_D,
  parameter int MAX_STEPS       = pfgc_pkg::MAX_STEPS_D
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         mode,
  input  wire logic [5:0]         instr_index,
  input  wire logic [2:0]         step_index,
  input  wire logic [2:0]         source_fifo,
  input  wire logic [4:0]         range_lo,
  input  wire logic [4:0]         range_hi,
  input  wire logic               pop_after,
  input  wire logic               last_step,
  input  wire logic [1:0]         channel,
  input  wire logic [4:0]         element_index,
  input  wire logic signed [15:0] element_value,
  output logic                    strobe,
  output logic signed [15:0]      out_value,
  output logic [4:0]              out_position,
  output logic [1:0]              dest_channel,
  output logic                    last_of_vector,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  pfgc_pkg::cmd_t cmd;
  pfgc_pkg::sts_t sts;
  logic [6:0]     prog_len;
  logic [2:0]     out_chs;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len <= 7'd1;
      out_chs  <= 3'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        pfgc_pkg::REG_PROG_LEN: prog_len <= pwdata[6:0];
        pfgc_pkg::REG_OUT_CHS:  out_chs  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pfgc_pkg::REG_PROG_LEN: prdata = {25'd0, prog_len};
      default:                prdata = {29'd0, out_chs};
    endcase
  end

  pfgc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .mode(mode),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  pfgc_dp #(
    .NUM_IN_CHANNELS(NUM_IN_CHANNELS), .IN_ELEMS(IN_ELEMS), .OUT_ELEMS(OUT_ELEMS),
    .FIFO_DEPTH(FIFO_DEPTH), .MAX_INSTR(MAX_INSTR), .MAX_STEPS(MAX_STEPS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .prog_len(prog_len), .out_chs(out_chs),
    .instr_index(instr_index), .step_index(step_index), .source_fifo(source_fifo),
    .range_lo(range_lo), .range_hi(range_hi),
    .pop_after(pop_after), .last_step(last_step), .channel(channel),
    .element_index(element_index), .element_value(element_value),
    .strobe(strobe), .out_value(out_value), .out_position(out_position),
    .dest_channel(dest_channel), .last_of_vector(last_of_vector)
  );

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last_of_vector |=> !strobe)
    else $error("transfer straight after end of vector");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_of_vector |-> busy)
    else $error("vector cut short");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy && $past(!busy) && !$past(rst) |-> !strobe)
    else $error("transfer while idle");

endmodule
`default_nettype wire

// ===== rtl/pfgc_ram.sv =====
// ----------------------------------------------------------------------------
// pfgc_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module pfgc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/pfgc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfgc_ctrl
// sequencer for load, element, word copy and tick walks
// ----------------------------------------------------------------------------
`default_nettype none
module pfgc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [1:0]     mode,
  input  wire pfgc_pkg::sts_t sts,
  output pfgc_pkg::cmd_t      cmd,
  output logic                busy
);

  typedef enum logic [3:0] {
    IDLE, CHK, STEP, EL_RD, EL_OUT, POP, PAD, PUSH_RD, PUSH_WR
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    cmd.sel    = pfgc_pkg::SEL_CUR;
    state_next = state;
    unique case (state)
      IDLE: begin
        cmd.sel = pfgc_pkg::SEL_IN;
        if (start) begin
          unique case (mode)
            pfgc_pkg::MODE_LOAD: cmd.load_wr = 1'b1;
            pfgc_pkg::MODE_ELEM: begin
              cmd.elem_wr = 1'b1;
              if (sts.elem_ok && sts.word_done && !sts.sel_full) begin
                cmd.push_begin = 1'b1;
                state_next     = PUSH_RD;
              end
            end
            pfgc_pkg::MODE_TICK: begin
              cmd.chk_begin = 1'b1;
              state_next    = CHK;
            end
            default: ;
          endcase
        end
      end
      CHK: begin
        cmd.sel = pfgc_pkg::SEL_TBL;
        if (sts.src_empty) begin
          state_next = IDLE;
        end else if (sts.tbl_final) begin
          cmd.run_begin = 1'b1;
          state_next    = STEP;
        end else begin
          cmd.chk_next = 1'b1;
        end
      end
      STEP: begin
        cmd.sel        = pfgc_pkg::SEL_TBL;
        cmd.step_latch = 1'b1;
        state_next     = sts.tbl_no_range ? POP : EL_RD;
      end
      EL_RD: state_next = EL_OUT;
      EL_OUT: begin
        cmd.el_out = 1'b1;
        state_next = sts.k_end ? POP : EL_RD;
      end
      POP: begin
        cmd.step_end = 1'b1;
        state_next   = sts.step_final ? PAD : STEP;
      end
      PAD: begin
        cmd.pad = 1'b1;
        if (sts.eid_last) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      PUSH_RD: begin
        cmd.push_rd = 1'b1;
        state_next  = PUSH_WR;
      end
      PUSH_WR: begin
        cmd.push_wr = 1'b1;
        state_next  = sts.push_last ? IDLE : PUSH_RD;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != IDLE);

endmodule
`default_nettype wire

// ===== rtl/pfgc_dp.sv =====
// ----------------------------------------------------------------------------
// pfgc_dp
// tables, input fifos, word buffers, counters and result register
// ----------------------------------------------------------------------------
`default_nettype none
module pfgc_dp #(
  parameter int NUM_IN_CHANNELS = pfgc_pkg::NUM_IN_CHANNELS_D,
  parameter int IN_ELEMS        = pfgc_pkg::IN_ELEMS_D,
  parameter int OUT_ELEMS       = pfgc_pkg::OUT_ELEMS_D,
  parameter int FIFO_DEPTH      = pfgc_pkg::FIFO_DEPTH_D,
  parameter int MAX_INSTR       = pfgc_pkg::MAX_INSTR_D,
  parameter int MAX_STEPS       = pfgc_pkg::MAX_STEPS_D
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pfgc_pkg::cmd_t     cmd,
  output pfgc_pkg::sts_t          sts,
  input  wire logic [6:0]         prog_len,
  input  wire logic [2:0]         out_chs,
  input  wire logic [5:0]         instr_index,
  input  wire logic [2:0]         step_index,
  input  wire logic [2:0]         source_fifo,
  input  wire logic [4:0]         range_lo,
  input  wire logic [4:0]         range_hi,
  input  wire logic               pop_after,
  input  wire logic               last_step,
  input  wire logic [1:0]         channel,
  input  wire logic [4:0]         element_index,
  input  wire logic signed [15:0] element_value,
  output logic                    strobe,
  output logic signed [15:0]      out_value,
  output logic [4:0]              out_position,
  output logic [1:0]              dest_channel,
  output logic                    last_of_vector
);

  localparam int PC_W  = MAX_INSTR > 1 ? $clog2(MAX_INSTR) : 1;
  localparam int LW    = PC_W + 1 > 7 ? PC_W + 1 : 7;
  localparam int S_W   = MAX_STEPS > 1 ? $clog2(MAX_STEPS) : 1;
  localparam int TDEP  = MAX_INSTR * MAX_STEPS;
  localparam int TA_W  = TDEP > 1 ? $clog2(TDEP) : 1;
  localparam int CH_W  = NUM_IN_CHANNELS > 1 ? $clog2(NUM_IN_CHANNELS) : 1;
  localparam int FP_W  = $clog2(FIFO_DEPTH);
  localparam int CN_W  = $clog2(FIFO_DEPTH + 1);
  localparam int EI_W  = $clog2(IN_ELEMS);
  localparam int SDEP  = NUM_IN_CHANNELS * FIFO_DEPTH * IN_ELEMS;
  localparam int SA_W  = $clog2(SDEP);
  localparam int BDEP  = NUM_IN_CHANNELS * IN_ELEMS;
  localparam int BA_W  = $clog2(BDEP);
  localparam int EID_W = $clog2(OUT_ELEMS + 1);

  logic [PC_W-1:0]  pc;
  logic [1:0]       dest;
  logic [S_W-1:0]   s, s_next;
  logic [EID_W-1:0] eid;
  logic [4:0]       k, k_en;
  logic [EI_W-1:0]  pk;
  logic [CH_W-1:0]  cur_ch, sel_ch, tbl_ch;
  logic             have, pop_r, final_r, bvalid_r;
  logic [FP_W-1:0]  head [NUM_IN_CHANNELS];
  logic [FP_W-1:0]  tail [NUM_IN_CHANNELS];
  logic [CN_W-1:0]  cnt  [NUM_IN_CHANNELS];
  logic [BDEP-1:0]  bvalid;

  logic [pfgc_pkg::ENTRY_W-1:0] tbl_rdata, tbl_wdata;
  logic [TA_W-1:0]  tbl_waddr, tbl_raddr;
  logic             tbl_we;
  logic [15:0]      st_rdata, st_wdata;
  logic [SA_W-1:0]  st_waddr, st_raddr;
  logic [15:0]      bf_rdata;
  logic [BA_W-1:0]  bf_waddr, bf_raddr;
  logic             bf_we;

  logic [2:0]       t_src;
  logic [4:0]       t_st, t_en;
  logic             t_pop, t_last, t_ok;
  logic             emit, in_ok_elem;
  logic [LW-1:0]    len_m1;
  logic [1:0]       dch_m1;

  // table entry fields
  assign t_src  = tbl_rdata[2:0];
  assign t_st   = tbl_rdata[7:3];
  assign t_en   = tbl_rdata[12:8];
  assign t_pop  = tbl_rdata[13];
  assign t_last = tbl_rdata[14];
  assign t_ok   = (t_src != 3'd0) && (32'(t_src) <= NUM_IN_CHANNELS);
  assign tbl_ch = CH_W'(t_src - 3'd1);

  always_comb begin
    unique case (cmd.sel)
      pfgc_pkg::SEL_IN:  sel_ch = CH_W'(channel);
      pfgc_pkg::SEL_TBL: sel_ch = tbl_ch;
      default:           sel_ch = cur_ch;
    endcase
  end

  always_comb begin
    s_next = s;
    if (cmd.chk_begin || cmd.run_begin) begin
      s_next = '0;
    end else if (cmd.chk_next || (cmd.step_end && !final_r)) begin
      s_next = s + S_W'(1);
    end
  end

  // instruction table
  assign tbl_we    = cmd.load_wr && (32'(instr_index) < MAX_INSTR)
                     && (32'(step_index) < MAX_STEPS);
  assign tbl_waddr = TA_W'(32'(instr_index) * MAX_STEPS + 32'(step_index));
  assign tbl_wdata = {last_step, pop_after, range_hi, range_lo, source_fifo};
  assign tbl_raddr = TA_W'(32'(pc) * MAX_STEPS + 32'(s_next));

  pfgc_ram #(.WIDTH(pfgc_pkg::ENTRY_W), .DEPTH(TDEP)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  // word assembly buffer
  assign in_ok_elem = (32'(channel) < NUM_IN_CHANNELS) && (32'(element_index) < IN_ELEMS);
  assign bf_we      = cmd.elem_wr && in_ok_elem;
  assign bf_waddr   = BA_W'(32'(channel) * IN_ELEMS + 32'(element_index));
  assign bf_raddr   = BA_W'(32'(cur_ch) * IN_ELEMS + 32'(pk));

  pfgc_ram #(.WIDTH(16), .DEPTH(BDEP)) u_buf (
    .clk(clk), .we(bf_we), .waddr(bf_waddr), .wdata(element_value),
    .raddr(bf_raddr), .rdata(bf_rdata)
  );

  // input fifo store
  assign st_waddr = SA_W'((32'(cur_ch) * FIFO_DEPTH + 32'(tail[cur_ch])) * IN_ELEMS
                          + 32'(pk));
  assign st_wdata = bvalid_r ? bf_rdata : 16'd0;
  assign st_raddr = SA_W'((32'(cur_ch) * FIFO_DEPTH + 32'(head[cur_ch])) * IN_ELEMS
                          + 32'(k[EI_W > 5 ? 4 : EI_W-1:0]));

  pfgc_ram #(.WIDTH(16), .DEPTH(SDEP)) u_store (
    .clk(clk), .we(cmd.push_wr), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // wrap limits
  always_comb begin
    if (prog_len == 7'd0) begin
      len_m1 = '0;
    end else if (32'(prog_len) > MAX_INSTR) begin
      len_m1 = LW'(MAX_INSTR - 1);
    end else begin
      len_m1 = LW'(prog_len) - LW'(1);
    end
    if (out_chs == 3'd0) begin
      dch_m1 = 2'd0;
    end else if (out_chs > 3'd4) begin
      dch_m1 = 2'd3;
    end else begin
      dch_m1 = 2'(out_chs - 3'd1);
    end
  end

  assign emit = (cmd.el_out || cmd.pad) && (32'(eid) < OUT_ELEMS);

  always_ff @(posedge clk) begin
    s        <= s_next;
    bvalid_r <= bvalid[bf_raddr];
    if (cmd.elem_wr) begin
      cur_ch <= CH_W'(channel);
    end
    if (cmd.step_latch) begin
      cur_ch  <= tbl_ch;
      have    <= t_ok && (cnt[tbl_ch] != '0);
      pop_r   <= t_pop;
      final_r <= t_last || (s == S_W'(MAX_STEPS - 1));
      k       <= t_st;
      k_en    <= t_en;
    end else if (cmd.el_out && (k != k_en)) begin
      k <= k + 5'd1;
    end
    if (cmd.push_begin) begin
      pk <= '0;
    end else if (cmd.push_wr) begin
      pk <= pk + EI_W'(1);
    end
    if (cmd.run_begin) begin
      eid <= '0;
    end else if (emit) begin
      eid <= eid + EID_W'(1);
    end
    out_value      <= (cmd.el_out && have && (32'(k) < IN_ELEMS)) ? st_rdata : 16'sd0;
    out_position   <= 5'(eid);
    dest_channel   <= dest;
    last_of_vector <= (32'(eid) == OUT_ELEMS - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      pc     <= '0;
      dest   <= '0;
      bvalid <= '0;
      for (int i = 0; i < NUM_IN_CHANNELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        cnt[i]  <= '0;
      end
    end else begin
      strobe <= emit;
      if (bf_we) begin
        bvalid[bf_waddr] <= 1'b1;
      end
      if (cmd.push_wr && (32'(pk) == IN_ELEMS - 1)) begin
        tail[cur_ch] <= (32'(tail[cur_ch]) == FIFO_DEPTH - 1) ? '0
                        : tail[cur_ch] + FP_W'(1);
        cnt[cur_ch]  <= cnt[cur_ch] + CN_W'(1);
      end
      if (cmd.step_end && have && pop_r) begin
        head[cur_ch] <= (32'(head[cur_ch]) == FIFO_DEPTH - 1) ? '0
                        : head[cur_ch] + FP_W'(1);
        cnt[cur_ch]  <= cnt[cur_ch] - CN_W'(1);
      end
      if (cmd.finish) begin
        pc   <= (LW'(pc) >= len_m1) ? '0 : pc + PC_W'(1);
        dest <= (dest >= dch_m1) ? 2'd0 : dest + 2'd1;
      end
    end
  end

  always_comb begin
    sts.elem_ok      = in_ok_elem;
    sts.word_done    = (32'(element_index) == IN_ELEMS - 1);
    sts.sel_full     = (32'(cnt[sel_ch]) >= FIFO_DEPTH);
    sts.src_empty    = t_ok && (cnt[sel_ch] == '0);
    sts.tbl_final    = t_last || (s == S_W'(MAX_STEPS - 1));
    sts.tbl_no_range = (t_st > t_en);
    sts.k_end        = (k == k_en);
    sts.step_final   = final_r;
    sts.push_last    = (32'(pk) == IN_ELEMS - 1);
    sts.eid_last     = (32'(eid) >= OUT_ELEMS - 1);
  end

endmodule
`default_nettype wire
